[hw/rtl/mhlme_pkg.sv]
// ----------------------------------------------------------------------------
// mhlme_pkg
// Shared types, codes and default sizes for the multi hull line max engine.
// ----------------------------------------------------------------------------
package mhlme_pkg;

    // default configuration
    localparam int HULLS_DEF = 16;
    localparam int LINES_DEF = 64;

    // fixed field widths
    localparam int SLOPE_W     = 21;
    localparam int INTERCEPT_W = 48;
    localparam int QX_W        = 20;
    localparam int BEST_W      = 49;
    localparam int HULL_IDX_W  = 4;
    localparam int STATUS_W    = 2;

    // derived arithmetic widths
    localparam int DC_W    = INTERCEPT_W + 1;   // difference of two intercepts
    localparam int DM_W    = SLOPE_W + 1;       // difference of two slopes
    localparam int POP_W   = DC_W + DM_W;       // pop test products
    localparam int WALK_W  = QX_W + 1 + DM_W;   // x times slope difference
    localparam int BPROD_W = SLOPE_W + QX_W;    // slope times x, unsigned

    // operation codes
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // one stored line
    typedef struct packed {
        logic [SLOPE_W-1:0]            slope;
        logic signed [INTERCEPT_W-1:0] intercept;
    } line_t;

    localparam int LINE_W = SLOPE_W + INTERCEPT_W;

endpackage

[hw/rtl/multi_hull_line_max_engine_top.sv]
// ----------------------------------------------------------------------------
// multi_hull_line_max_engine_top
// Several independent upper hulls of lines for a monotone convex hull trick.
// Sequence: an out-of-range word or an empty-hull query goes straight to the
// result; an add to a hull under two lines is written directly; else an add
// runs pop tests and a query runs walk tests, each one line read, multiply
// and compare. One word at a time: the next is taken once the result is out.
// Reset: asynchronous active low; clears hull sizes and query pointers, the
// line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module multi_hull_line_max_engine_top #(
    parameter int HULLS = mhlme_pkg::HULLS_DEF,
    parameter int LINES = mhlme_pkg::LINES_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      item_valid,
    output logic                                      item_stall,
    input  logic                                      kind,
    input  logic [mhlme_pkg::HULL_IDX_W-1:0]          hull_index,
    input  logic [mhlme_pkg::SLOPE_W-1:0]             slope,
    input  logic signed [mhlme_pkg::INTERCEPT_W-1:0]  intercept,
    input  logic [mhlme_pkg::QX_W-1:0]                query_x,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output logic signed [mhlme_pkg::BEST_W-1:0]       best_value,
    output logic [mhlme_pkg::STATUS_W-1:0]            status
);

    localparam int HW    = (HULLS > 1) ? $clog2(HULLS) : 1;
    localparam int PW    = $clog2(LINES);
    localparam int SW    = $clog2(LINES + 1);
    localparam int DEPTH = HULLS * LINES;
    localparam int AW    = $clog2(DEPTH);
    localparam int DC_W  = mhlme_pkg::DC_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD_RDA = 4'd1;
    localparam logic [3:0] S_ADD_MUL = 4'd2;
    localparam logic [3:0] S_ADD_CMP = 4'd3;
    localparam logic [3:0] S_ADD_FIN = 4'd4;
    localparam logic [3:0] S_Q_RD1   = 4'd5;
    localparam logic [3:0] S_Q_MUL   = 4'd6;
    localparam logic [3:0] S_Q_CMP   = 4'd7;
    localparam logic [3:0] S_Q_VAL   = 4'd8;
    localparam logic [3:0] S_Q_OUT   = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    logic [3:0] state_reg, state_next;

    // per hull control state
    logic [SW-1:0] size_mem [HULLS];
    logic [PW-1:0] ptr_mem  [HULLS];

    // latched word
    logic [HW-1:0]                           h_reg;
    logic [mhlme_pkg::SLOPE_W-1:0]           mp_reg;
    logic signed [mhlme_pkg::INTERCEPT_W-1:0] cp_reg;
    logic [mhlme_pkg::QX_W-1:0]              x_reg;
    logic [SW-1:0]                           k_reg;
    logic [SW-1:0]                           size_reg;

    // line registers and products
    mhlme_pkg::line_t                         a_reg, b_reg;
    logic signed [mhlme_pkg::POP_W-1:0]       pa_reg, pb_reg;
    logic signed [mhlme_pkg::WALK_W-1:0]      pq_reg;
    logic [mhlme_pkg::BPROD_W-1:0]            bp_reg;

    // result staging
    logic signed [mhlme_pkg::BEST_W-1:0]      res_best_reg;
    logic [mhlme_pkg::STATUS_W-1:0]           res_status_reg;
    logic                                     out_valid_reg;
    logic signed [mhlme_pkg::BEST_W-1:0]      out_best_reg;
    logic [mhlme_pkg::STATUS_W-1:0]           out_status_reg;

    // memory port signals
    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [SW-1:0]        rd_idx;
    logic [mhlme_pkg::LINE_W-1:0] rd_raw;
    mhlme_pkg::line_t     rd_line, wr_line;

    logic                 accept;
    logic                 h_in_range;
    logic [HW-1:0]        h_in;
    logic [SW-1:0]        size_in;
    logic [SW-1:0]        ptr_in_ext;
    logic [SW-1:0]        k_clip;
    logic                 out_free;

    // pop and walk tests
    logic signed [mhlme_pkg::DC_W-1:0] dcb, dcq;
    logic signed [mhlme_pkg::DM_W-1:0] dmp, dmb, dmq;
    logic                              pop_hit, walk_stop;

    function automatic logic [AW-1:0] line_addr(input logic [HW-1:0] h,
                                                input logic [SW-1:0] idx);
        line_addr = AW'(h) * AW'(LINES) + AW'(idx);
    endfunction

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign h_in_range = (32'(hull_index) < HULLS);
    assign h_in       = HW'(hull_index);
    assign size_in    = size_mem[h_in];
    assign ptr_in_ext = SW'(ptr_mem[h_in]);
    assign k_clip     = (ptr_in_ext > size_in - SW'(1)) ? size_in - SW'(1) : ptr_in_ext;
    assign out_free   = !out_valid_reg || !result_stall;
    assign rd_line    = mhlme_pkg::line_t'(rd_raw);

    // pop test: (ca-cb)*(mp-mb) >= (cb-cp)*(mb-ma)
    assign dmp = $signed({1'b0, mp_reg}) - $signed({1'b0, b_reg.slope});
    assign dcb = DC_W'(b_reg.intercept) - DC_W'(cp_reg);
    assign dmb = $signed({1'b0, b_reg.slope}) - $signed({1'b0, rd_line.slope});
    assign pop_hit = (pa_reg >= pb_reg);

    // walk test: c[k]-c[k+1] >= x*(m[k+1]-m[k]) stops the walk
    assign dmq = $signed({1'b0, rd_line.slope}) - $signed({1'b0, a_reg.slope});
    assign dcq = DC_W'(a_reg.intercept) - DC_W'(b_reg.intercept);
    assign walk_stop = (dcq >= DC_W'(pq_reg));

    // read address selection
    always_comb
    begin
        rd_en  = 1'b0;
        rd_idx = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && h_in_range)
                begin
                    if (kind == mhlme_pkg::KIND_ADD && size_in > SW'(1))
                    begin
                        rd_en  = 1'b1;
                        rd_idx = size_in - SW'(1);
                    end
                    else if (kind == mhlme_pkg::KIND_QUERY && size_in != '0)
                    begin
                        rd_en  = 1'b1;
                        rd_idx = k_clip;
                    end
                end
            end
            S_ADD_RDA:
            begin
                rd_en  = 1'b1;
                rd_idx = k_reg - SW'(2);
            end
            S_ADD_CMP:
            begin
                if (pop_hit && k_reg > SW'(2))
                begin
                    rd_en  = 1'b1;
                    rd_idx = k_reg - SW'(3);
                end
            end
            S_Q_RD1:
            begin
                if (k_reg < size_reg - SW'(1))
                begin
                    rd_en  = 1'b1;
                    rd_idx = k_reg + SW'(1);
                end
            end
            S_Q_CMP:
            begin
                if (!walk_stop && k_reg + SW'(1) < size_reg - SW'(1))
                begin
                    rd_en  = 1'b1;
                    rd_idx = k_reg + SW'(2);
                end
            end
            default:
            begin
                rd_en  = 1'b0;
                rd_idx = '0;
            end
        endcase
    end

    assign rd_addr = line_addr((state_reg == S_IDLE) ? h_in : h_reg, rd_idx);
    assign wr_en   = (state_reg == S_ADD_FIN) && (k_reg < SW'(LINES));
    assign wr_addr = line_addr(h_reg, k_reg);
    assign wr_line = '{slope: mp_reg, intercept: cp_reg};

    mhlme_ram #(
        .WIDTH (mhlme_pkg::LINE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_line),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!h_in_range)
                        state_next = S_RESP;
                    else if (kind == mhlme_pkg::KIND_ADD)
                        state_next = (size_in > SW'(1)) ? S_ADD_RDA : S_ADD_FIN;
                    else
                        state_next = (size_in == '0) ? S_RESP : S_Q_RD1;
                end
            end
            S_ADD_RDA: state_next = S_ADD_MUL;
            S_ADD_MUL: state_next = S_ADD_CMP;
            S_ADD_CMP:
                state_next = (pop_hit && k_reg > SW'(2)) ? S_ADD_MUL : S_ADD_FIN;
            S_ADD_FIN: state_next = S_RESP;
            S_Q_RD1:
                state_next = (k_reg < size_reg - SW'(1)) ? S_Q_MUL : S_Q_VAL;
            S_Q_MUL:   state_next = S_Q_CMP;
            S_Q_CMP:
                state_next = (!walk_stop && k_reg + SW'(1) < size_reg - SW'(1)) ?
                             S_Q_MUL : S_Q_VAL;
            S_Q_VAL:   state_next = S_Q_OUT;
            S_Q_OUT:   state_next = S_RESP;
            S_RESP:    state_next = out_free ? S_IDLE : S_RESP;
            default:   state_next = S_IDLE;
        endcase
    end

    // control state and per hull registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HULLS; i++)
            begin
                size_mem[i] <= '0;
                ptr_mem[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            // pointer backs off when its line is popped
            if (state_reg == S_ADD_CMP && pop_hit &&
                SW'(ptr_mem[h_reg]) == k_reg - SW'(1))
                ptr_mem[h_reg] <= ptr_mem[h_reg] - PW'(1);
            if (wr_en)
                size_mem[h_reg] <= k_reg + SW'(1);
            if (state_reg == S_Q_OUT)
                ptr_mem[h_reg] <= PW'(k_reg);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    h_reg          <= h_in;
                    mp_reg         <= slope;
                    cp_reg         <= intercept;
                    x_reg          <= query_x;
                    size_reg       <= size_in;
                    res_best_reg   <= '0;
                    k_reg          <= (kind == mhlme_pkg::KIND_ADD) ? size_in : k_clip;
                    if (!h_in_range)
                        res_status_reg <= (kind == mhlme_pkg::KIND_ADD) ?
                                          mhlme_pkg::STATUS_FULL : mhlme_pkg::STATUS_EMPTY;
                    else if (kind == mhlme_pkg::KIND_QUERY && size_in == '0)
                        res_status_reg <= mhlme_pkg::STATUS_EMPTY;
                    else
                        res_status_reg <= mhlme_pkg::STATUS_OK;
                end
            end
            S_ADD_RDA:
            begin
                b_reg <= rd_line;
            end
            S_ADD_MUL:
            begin
                a_reg  <= rd_line;
                pa_reg <= (DC_W'(rd_line.intercept) - DC_W'(b_reg.intercept)) * dmp;
                pb_reg <= dcb * dmb;
            end
            S_ADD_CMP:
            begin
                if (pop_hit)
                begin
                    k_reg <= k_reg - SW'(1);
                    b_reg <= a_reg;
                end
            end
            S_ADD_FIN:
            begin
                if (k_reg >= SW'(LINES))
                    res_status_reg <= mhlme_pkg::STATUS_FULL;
            end
            S_Q_RD1:
            begin
                a_reg <= rd_line;
            end
            S_Q_MUL:
            begin
                b_reg  <= rd_line;
                pq_reg <= $signed({1'b0, x_reg}) * dmq;
            end
            S_Q_CMP:
            begin
                if (!walk_stop)
                begin
                    k_reg <= k_reg + SW'(1);
                    a_reg <= b_reg;
                end
            end
            S_Q_VAL:
            begin
                bp_reg <= a_reg.slope * x_reg;
            end
            S_Q_OUT:
            begin
                res_best_reg <= $signed({1'b0, bp_reg}) + mhlme_pkg::BEST_W'(a_reg.intercept);
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_RESP && out_free)
        begin
            out_best_reg   <= res_best_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign best_value   = out_best_reg;
    assign status       = out_status_reg;

endmodule

[hw/rtl/mhlme_ram.sv]
// ----------------------------------------------------------------------------
// mhlme_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mhlme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/mhlme_checker.sv]
// ----------------------------------------------------------------------------
// mhlme_checker
// Port level checks for the multi hull line max engine.
// ----------------------------------------------------------------------------
module mhlme_checker (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     item_valid,
    input logic                                     item_stall,
    input logic                                     kind,
    input logic [mhlme_pkg::HULL_IDX_W-1:0]         hull_index,
    input logic [mhlme_pkg::SLOPE_W-1:0]            slope,
    input logic signed [mhlme_pkg::INTERCEPT_W-1:0] intercept,
    input logic [mhlme_pkg::QX_W-1:0]               query_x,
    input logic                                     result_valid,
    input logic                                     result_stall,
    input logic signed [mhlme_pkg::BEST_W-1:0]      best_value,
    input logic [mhlme_pkg::STATUS_W-1:0]           status
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(best_value) && $stable(status))
        else $error("stalled result changed");

    // status is a defined code whenever a result is valid
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status <= mhlme_pkg::STATUS_FULL)
        else $error("undefined status code");

    // results with an error status report zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != mhlme_pkg::STATUS_OK |-> best_value == '0)
        else $error("nonzero value with error status");

    // one item at a time: busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second word taken while busy");

endmodule

bind multi_hull_line_max_engine_top mhlme_checker u_mhlme_checker (.*);
